>>> rtl/core/fba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fba_pkg: shared types and constants of the frame bitmap allocator
// Command codes, datapath operation codes, controller/datapath handshake
// structs and the lowest-zero search used on 32-bit bitmap words.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;   // bit position inside one bitmap word
  localparam int FRAME_W   = 20;  // frame number width
  localparam int FIDX_W    = 15;  // frame number without its bit position
  localparam int FC_W      = 16;  // frame_count register width
  localparam int LIM_W     = 21;  // wide enough to hold any frame limit

  localparam logic [FC_W-1:0]      FC_RESET  = 16'h8000;
  localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

  // Request kinds
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_CLAIM = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;

  // Datapath operations issued by the controller
  localparam logic [2:0] OP_NOP    = 3'd0;
  localparam logic [2:0] OP_CLEAR  = 3'd1;
  localparam logic [2:0] OP_LOAD   = 3'd2;
  localparam logic [2:0] OP_GRP    = 3'd3;
  localparam logic [2:0] OP_WSEL   = 3'd4;
  localparam logic [2:0] OP_RD     = 3'd5;
  localparam logic [2:0] OP_COMMIT = 3'd6;
  localparam logic [2:0] OP_RESULT = 3'd7;

  typedef struct packed {
    logic [2:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_last;  // last word of the clearing pass
    logic [1:0] action;    // kind of the request held
    logic       cur_zero;  // request holds no current frame
    logic       mark_ok;   // claim or free touches the bitmap
    logic       grp_hit;   // some group still has a non-full word
    logic       word_ok;   // chosen word lies below the managed limit
  } dp_stat_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } zero_pos_t;

  function automatic zero_pos_t lowest_zero(input logic [WORD_BITS-1:0] w);
    zero_pos_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r.found = 1'b1;
        r.idx   = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/fba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fba_ctrl: request sequencer
// Walks the clearing pass after reset, then steps each request through
// search, read, write-back and result operations of the datapath.
// ----------------------------------------------------------------------------
module fba_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire fba_pkg::dp_stat_t stat,
  output fba_pkg::dp_cmd_t      cmd,
  output logic                  busy
);
  import fba_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_GRP    = 3'd3;
  localparam logic [2:0] S_WSEL   = 3'd4;
  localparam logic [2:0] S_RD     = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;
  localparam logic [2:0] S_RESULT = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (stat.action == ACT_ALLOC && stat.cur_zero) state_nxt = S_GRP;
        else if (stat.mark_ok) state_nxt = S_RD;
        else state_nxt = S_RESULT;
      end
      S_GRP: begin
        cmd.op    = OP_GRP;
        state_nxt = stat.grp_hit ? S_WSEL : S_RESULT;
      end
      S_WSEL: begin
        cmd.op    = OP_WSEL;
        state_nxt = stat.word_ok ? S_COMMIT : S_RESULT;
      end
      S_RD: begin
        cmd.op    = OP_RD;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.op    = OP_COMMIT;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        cmd.op    = OP_RESULT;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

>>> rtl/core/fba_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fba_datapath: bitmap, full-word summary and request registers
// Holds the used-frame bitmap, a summary memory with one full flag per
// bitmap word, one full flag per summary word in flops, and the result.
// ----------------------------------------------------------------------------
module fba_datapath #(
  parameter int MAX_FRAMES = 32768
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire fba_pkg::dp_cmd_t           cmd,
  output fba_pkg::dp_stat_t               stat,
  input  wire logic                       cfg_we,
  input  wire logic [fba_pkg::FC_W-1:0]   cfg_data,
  input  wire logic [1:0]                 in_action,
  input  wire logic [fba_pkg::FRAME_W-1:0] in_current_frame,
  input  wire logic [fba_pkg::FRAME_W-1:0] in_target_frame,
  input  wire logic                       in_is_kernel,
  input  wire logic                       in_is_writeable,
  output logic                            out_valid,
  output logic [fba_pkg::FRAME_W-1:0]     out_frame,
  output logic                            out_present,
  output logic                            out_writable,
  output logic                            out_user_mode,
  output logic                            out_status
);
  import fba_pkg::*;

  localparam int WORDS   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int GROUPS  = (WORDS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int GRP_AW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  // Storage
  logic [WORD_BITS-1:0] bitmap  [WORDS];
  logic [WORD_BITS-1:0] summary [GROUPS];
  logic [GROUPS-1:0]    grp_full_r;
  logic [WORD_BITS-1:0] bm_q_r;
  logic [WORD_BITS-1:0] sum_q_r;
  logic [WORD_AW-1:0]   clr_cnt_r;
  logic [FC_W-1:0]      fc_r;

  // Request registers
  logic [1:0]         act_r;
  logic [FRAME_W-1:0] cur_r;
  logic [FRAME_W-1:0] tgt_r;
  logic               kern_r;
  logic               wr_r;
  logic               fail_r;
  logic [FIDX_W-1:0]  widx_r;
  logic [GRP_AW-1:0]  g_r;
  logic [BIT_W-1:0]   bit_r;

  // Result registers
  logic               out_valid_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic               out_present_r;
  logic               out_writable_r;
  logic               out_user_r;
  logic               out_status_r;

  // Limits
  logic [LIM_W-1:0] managed;
  logic [LIM_W-1:0] nwords;
  always_comb begin
    managed = (LIM_W'(fc_r) > LIM_W'(MAX_FRAMES)) ? LIM_W'(MAX_FRAMES) : LIM_W'(fc_r);
    nwords  = managed >> BIT_W;
  end

  // Lowest group that still holds a non-full word
  logic [GRP_AW-1:0] g_hit;
  always_comb begin
    g_hit = '0;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (!grp_full_r[i]) g_hit = GRP_AW'(i);
    end
  end

  // Word choice inside the group just read
  zero_pos_t         zs;
  logic [FIDX_W-1:0] widx_c;
  always_comb begin
    zs     = lowest_zero(sum_q_r);
    widx_c = FIDX_W'({g_r, zs.idx});
  end

  logic [GRP_AW-1:0]  ga;
  logic [WORD_AW-1:0] wa;
  assign ga = GRP_AW'(widx_r >> BIT_W);
  assign wa = widx_r[WORD_AW-1:0];

  // Modify one word and its summary flag
  zero_pos_t            zb;
  logic [BIT_W-1:0]     bit_c;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] bm_new;
  logic [WORD_BITS-1:0] sum_new;
  always_comb begin
    zb = lowest_zero(bm_q_r);
    unique case (act_r)
      ACT_CLAIM: bit_c = tgt_r[BIT_W-1:0];
      ACT_FREE:  bit_c = cur_r[BIT_W-1:0];
      default:   bit_c = zb.idx;
    endcase
    mask    = WORD_BITS'(1) << bit_c;
    bm_new  = (act_r == ACT_FREE) ? (bm_q_r & ~mask) : (bm_q_r | mask);
    sum_new = sum_q_r;
    sum_new[widx_r[BIT_W-1:0]] = (bm_new == FULL_WORD);
  end

  // Status to the controller
  always_comb begin
    stat.clr_last = (clr_cnt_r == WORD_AW'(WORDS - 1));
    stat.action   = act_r;
    stat.cur_zero = (cur_r == '0);
    stat.mark_ok  = ((act_r == ACT_CLAIM) && (LIM_W'(tgt_r) < managed)) ||
                    ((act_r == ACT_FREE) && (cur_r != '0) &&
                     (LIM_W'(cur_r) < LIM_W'(MAX_FRAMES)));
    stat.grp_hit  = ~&grp_full_r;
    stat.word_ok  = zs.found && (LIM_W'(widx_c) < nwords);
  end

  // Memory ports
  logic                 clr_in_grp;
  logic                 bm_we;
  logic                 bm_re;
  logic [WORD_AW-1:0]   bm_wa;
  logic [WORD_AW-1:0]   bm_ra;
  logic [WORD_BITS-1:0] bm_wd;
  logic                 sum_we;
  logic                 sum_re;
  logic [GRP_AW-1:0]    sum_wa;
  logic [GRP_AW-1:0]    sum_ra;
  logic [WORD_BITS-1:0] sum_wd;
  always_comb begin
    clr_in_grp = ((WORD_AW + 1)'(clr_cnt_r) < (WORD_AW + 1)'(GROUPS));
    bm_we      = (cmd.op == OP_CLEAR) || (cmd.op == OP_COMMIT);
    bm_wa      = (cmd.op == OP_CLEAR) ? clr_cnt_r : wa;
    bm_wd      = (cmd.op == OP_CLEAR) ? '0 : bm_new;
    bm_re      = (cmd.op == OP_WSEL) || (cmd.op == OP_RD);
    bm_ra      = (cmd.op == OP_WSEL) ? widx_c[WORD_AW-1:0] : wa;
    sum_we     = ((cmd.op == OP_CLEAR) && clr_in_grp) || (cmd.op == OP_COMMIT);
    sum_wa     = (cmd.op == OP_CLEAR) ? GRP_AW'(clr_cnt_r) : ga;
    sum_wd     = (cmd.op == OP_CLEAR) ? '0 : sum_new;
    sum_re     = (cmd.op == OP_GRP) || (cmd.op == OP_RD);
    sum_ra     = (cmd.op == OP_GRP) ? g_hit : ga;
  end

  always_ff @(posedge clk) begin
    if (bm_we) bitmap[bm_wa] <= bm_wd;
    if (bm_re) bm_q_r <= bitmap[bm_ra];
  end

  always_ff @(posedge clk) begin
    if (sum_we) summary[sum_wa] <= sum_wd;
    if (sum_re) sum_q_r <= summary[sum_ra];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_full_r  <= '0;
      clr_cnt_r   <= '0;
      fc_r        <= FC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) fc_r <= cfg_data;
      if (cmd.op == OP_CLEAR) clr_cnt_r <= clr_cnt_r + WORD_AW'(1);
      if (cmd.op == OP_COMMIT) grp_full_r[ga] <= (sum_new == FULL_WORD);
      out_valid_r <= (cmd.op == OP_RESULT);
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        act_r  <= in_action;
        cur_r  <= in_current_frame;
        tgt_r  <= in_target_frame;
        kern_r <= in_is_kernel;
        wr_r   <= in_is_writeable;
        fail_r <= 1'b0;
        widx_r <= (in_action == ACT_CLAIM) ? in_target_frame[FRAME_W-1:BIT_W]
                                           : in_current_frame[FRAME_W-1:BIT_W];
      end
      OP_GRP: begin
        g_r <= g_hit;
        if (!stat.grp_hit) fail_r <= 1'b1;
      end
      OP_WSEL: begin
        widx_r <= widx_c;
        if (!stat.word_ok) fail_r <= 1'b1;
      end
      OP_COMMIT: begin
        bit_r <= bit_c;
      end
      OP_RESULT: begin
        out_frame_r    <= '0;
        out_present_r  <= 1'b0;
        out_writable_r <= 1'b0;
        out_user_r     <= 1'b0;
        out_status_r   <= 1'b0;
        if (act_r == ACT_ALLOC) begin
          if (fail_r) begin
            out_status_r <= 1'b1;
          end else begin
            out_frame_r    <= (cur_r != '0) ? cur_r : {widx_r, bit_r};
            out_present_r  <= 1'b1;
            out_writable_r <= wr_r;
            out_user_r     <= ~kern_r;
          end
        end else if (act_r == ACT_CLAIM) begin
          out_frame_r    <= tgt_r;
          out_present_r  <= 1'b1;
          out_writable_r <= wr_r;
          out_user_r     <= ~kern_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_frame     = out_frame_r;
  assign out_present   = out_present_r;
  assign out_writable  = out_writable_r;
  assign out_user_mode = out_user_r;
  assign out_status    = out_status_r;

endmodule
`default_nettype wire

>>> rtl/core/frame_bitmap_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Steps: after the accepting edge, an allocate that searches walks DECIDE, GRP,
//   WSEL, COMMIT and RESULT (leaving for RESULT early if it fails), a bitmap claim
//   or free walks DECIDE, RD, COMMIT and RESULT, any other request DECIDE and RESULT;
//   out_valid is registered from RESULT. One request at a time; start is taken again in
//   the strobe cycle. Reset: a clearing pass zeroes all MAX_FRAMES/32 bitmap words
//   with busy high; results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_top: first-fit physical frame allocator
// Allocate, claim and free requests over a used-frame bitmap kept in memory,
// with a full-word summary that takes the search straight to a free word.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_top #(
  parameter int MAX_FRAMES = 32768
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  in_action,
  input  wire logic [fba_pkg::FRAME_W-1:0] in_current_frame,
  input  wire logic [fba_pkg::FRAME_W-1:0] in_target_frame,
  input  wire logic                        in_is_kernel,
  input  wire logic                        in_is_writeable,
  // result channel
  output logic                             out_valid,
  output logic [fba_pkg::FRAME_W-1:0]      out_frame,
  output logic                             out_present,
  output logic                             out_writable,
  output logic                             out_user_mode,
  output logic                             out_status,
  // frame_count register
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [fba_pkg::FC_W-1:0]    cfg_data
);
  import fba_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration is to be written only while idle; the block itself does not enforce this, so always take it.
  assign cfg_ready = 1'b1;

  // Sequencer: clearing pass, then one request walked through its steps.
  fba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Bitmap, summary, request hold and result registers.
  fba_datapath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_data         (cfg_data),
    .in_action        (in_action),
    .in_current_frame (in_current_frame),
    .in_target_frame  (in_target_frame),
    .in_is_kernel     (in_is_kernel),
    .in_is_writeable  (in_is_writeable),
    .out_valid        (out_valid),
    .out_frame        (out_frame),
    .out_present      (out_present),
    .out_writable     (out_writable),
    .out_user_mode    (out_user_mode),
    .out_status       (out_status)
  );

  // An accepted request always makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  // A result strobe lasts one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // The strobe only appears once the request has finished.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  // A failed allocate hands out nothing.
  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_frame == '0 && !out_present))
    else $error("failed allocate returned a frame");

endmodule
`default_nettype wire

>>> verif/frame_bitmap_allocator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_top_test: self-checking bench for the frame allocator
// Drives allocate, claim and free requests through the start/busy port and
// keeps its own copy of the used-frame bitmap to predict every page entry.
// Each strobed result is checked field by field. The frame_count register is
// swept over several values between phases, the extremes among them.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_top_test;
  import fba_pkg::*;

  localparam int         FRAMES     = 32768;
  localparam int         MAP_WORDS  = FRAMES / WORD_BITS;
  localparam logic [1:0] ACT_NONE   = 2'd3;   // unused request code
  localparam int         PHASE_REQS = 250;

  typedef struct packed {
    logic [1:0]         act;
    logic [FRAME_W-1:0] cur;
    logic [FRAME_W-1:0] tgt;
    logic               kern;
    logic               wr;
  } request_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               writable;
    logic               user_mode;
    logic               status;
  } pte_result_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_action;
  logic [FRAME_W-1:0] in_current_frame;
  logic [FRAME_W-1:0] in_target_frame;
  logic               in_is_kernel;
  logic               in_is_writeable;
  logic               out_valid;
  logic [FRAME_W-1:0] out_frame;
  logic               out_present;
  logic               out_writable;
  logic               out_user_mode;
  logic               out_status;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [FC_W-1:0]    cfg_data;

  // Requests waiting for the driver, and page entries the block still owes.
  request_t    req_queue[$];
  pte_result_t entries_due[$];
  request_t    next_req;

  // Shadow of the block state: used-frame bitmap and frame_count register.
  logic [WORD_BITS-1:0] used_map[MAP_WORDS];
  logic [FC_W-1:0]      fc_model;

  int issued_count;
  int taken_count;
  int mismatch_count;
  int idle_pct;

  frame_bitmap_allocator_top #(
    .MAX_FRAMES(FRAMES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_current_frame (in_current_frame),
    .in_target_frame  (in_target_frame),
    .in_is_kernel     (in_is_kernel),
    .in_is_writeable  (in_is_writeable),
    .out_valid        (out_valid),
    .out_frame        (out_frame),
    .out_present      (out_present),
    .out_writable     (out_writable),
    .out_user_mode    (out_user_mode),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Apply one request to the shadow bitmap and return the page entry it yields.
  function automatic pte_result_t compute_entry(input request_t r);
    pte_result_t e;
    int          limit;
    int          w;
    int          b;
    bit          hit;
    e     = '0;
    hit   = 1'b0;
    limit = (int'(fc_model) > FRAMES) ? FRAMES : int'(fc_model);
    case (r.act)
      ACT_ALLOC: begin
        if (r.cur != '0) begin
          // Entry already holds a frame: keep it, touch nothing.
          hit     = 1'b1;
          e.frame = r.cur;
        end else begin
          // First fit over whole words below the managed limit only.
          for (w = 0; w < limit / WORD_BITS && !hit; w++) begin
            if (used_map[w] != FULL_WORD) begin
              for (b = 0; b < WORD_BITS && !hit; b++) begin
                if (!used_map[w][b]) begin
                  hit            = 1'b1;
                  used_map[w][b] = 1'b1;
                  e.frame        = FRAME_W'(w * WORD_BITS + b);
                end
              end
            end
          end
        end
        if (hit) begin
          e.present   = 1'b1;
          e.writable  = r.wr;
          e.user_mode = !r.kern;
        end else begin
          e.status = 1'b1;
        end
      end
      ACT_CLAIM: begin
        // Out-of-range claims mark nothing but still report the frame.
        if (int'(r.tgt) < limit)
          used_map[r.tgt / WORD_BITS][r.tgt % WORD_BITS] = 1'b1;
        e.frame     = r.tgt;
        e.present   = 1'b1;
        e.writable  = r.wr;
        e.user_mode = !r.kern;
      end
      ACT_FREE: begin
        // Frame zero and frames past the storage are left alone.
        if (r.cur != '0 && int'(r.cur) < FRAMES)
          used_map[r.cur / WORD_BITS][r.cur % WORD_BITS] = 1'b0;
      end
      default: ;
    endcase
    return e;
  endfunction

  // Driver: present a request at the falling edge, hold it until taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!start || taken_count == issued_count) begin
        if (req_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_req         = req_queue.pop_front();
          start            <= 1'b1;
          in_action        <= next_req.act;
          in_current_frame <= next_req.cur;
          in_target_frame  <= next_req.tgt;
          in_is_kernel     <= next_req.kern;
          in_is_writeable  <= next_req.wr;
          issued_count     <= issued_count + 1;
        end else begin
          // Idle: drop start and scramble the payload.
          start            <= 1'b0;
          in_action        <= 2'($urandom);
          in_current_frame <= FRAME_W'($urandom);
          in_target_frame  <= FRAME_W'($urandom);
          in_is_kernel     <= 1'($urandom);
          in_is_writeable  <= 1'($urandom);
        end
      end
    end
  end

  // Monitor: track register writes, check strobed results, predict on accept.
  always @(posedge clk) begin
    pte_result_t got;
    pte_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready)
        fc_model = cfg_data;
      if (out_valid) begin
        got = '{out_frame, out_present, out_writable, out_user_mode, out_status};
        if (entries_due.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected result frame=%0h present=%0b writable=%0b",
                     $realtime, got.frame, got.present, got.writable,
                     " user=%0b status=%0b", got.user_mode, got.status);
          mismatch_count++;
        end else begin
          want = entries_due.pop_front();
          if (got.frame !== want.frame || got.present !== want.present ||
              got.writable !== want.writable || got.user_mode !== want.user_mode ||
              got.status !== want.status) begin
            if (mismatch_count < 10)
              $display("%0t: mismatch exp frame=%0h p=%0b w=%0b u=%0b s=%0b,",
                       $realtime, want.frame, want.present, want.writable,
                       want.user_mode, want.status,
                       " got frame=%0h p=%0b w=%0b u=%0b s=%0b",
                       got.frame, got.present, got.writable, got.user_mode,
                       got.status);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        entries_due.push_back(compute_entry('{in_action, in_current_frame, in_target_frame,
                                              in_is_kernel, in_is_writeable}));
        taken_count <= taken_count + 1;
      end
    end
  end

  task automatic push_req(input logic [1:0] act, input int cur, input int tgt,
                          input bit kern, input bit wr);
    req_queue.push_back('{act, FRAME_W'(cur), FRAME_W'(tgt), kern, wr});
  endtask

  // Random request, weighted toward allocate/free churn inside the low span
  // so the bitmap fills, empties and refills instead of staying sparse.
  function automatic request_t random_request(input int span);
    request_t r;
    int       pick;
    r.cur  = FRAME_W'($urandom);
    r.tgt  = FRAME_W'($urandom);
    r.kern = 1'($urandom);
    r.wr   = 1'($urandom);
    pick   = $urandom_range(99);
    if (pick < 45) begin
      r.act = ACT_ALLOC;
      r.cur = '0;
    end else if (pick < 52) begin
      r.act = ACT_ALLOC;
      if (r.cur == '0)
        r.cur = FRAME_W'(1);
    end else if (pick < 67) begin
      r.act = ACT_CLAIM;
      if ($urandom_range(3) != 0)
        r.tgt = FRAME_W'($urandom_range(span - 1));
    end else if (pick < 95) begin
      r.act = ACT_FREE;
      case ($urandom_range(9))
        0:       r.cur = '0;
        1:       ;  // anywhere in the 20-bit range, mostly past the storage
        default: r.cur = FRAME_W'($urandom_range(span - 1));
      endcase
    end else begin
      r.act = ACT_NONE;
    end
    return r;
  endfunction

  // Wait until every request is taken and every entry has come back.
  task automatic drain();
    do
      @(posedge clk);
    while (req_queue.size() != 0 || taken_count != issued_count ||
           entries_due.size() != 0);
  endtask

  task automatic write_frame_count(input logic [FC_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do
      @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= FC_W'($urandom);
  endtask

  // Stimulus sequence.
  initial begin
    logic [FC_W-1:0] fc_plan[$];
    int              managed;
    int              span;
    int              p;
    int              i;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_action        = '0;
    in_current_frame = '0;
    in_target_frame  = '0;
    in_is_kernel     = 1'b0;
    in_is_writeable  = 1'b0;
    cfg_valid        = 1'b0;
    cfg_data         = '0;
    issued_count     = 0;
    taken_count      = 0;
    mismatch_count   = 0;
    idle_pct         = 26;
    fc_model         = FC_RESET;
    foreach (used_map[k])
      used_map[k] = '0;

    // Hold reset, then release it; the clearing pass runs afterwards with busy high.
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset frame_count.
    push_req(ACT_ALLOC, 0, 0, 1'b0, 1'b1);              // frame zero handed out
    push_req(ACT_ALLOC, 0, 'hFFFFF, 1'b1, 1'b0);        // next lowest free
    push_req(ACT_ALLOC, 'hFFFFF, 0, 1'b0, 1'b1);        // keep held frame
    push_req(ACT_CLAIM, 0, 'hFFFFF, 1'b0, 1'b1);        // claim out of range
    push_req(ACT_CLAIM, 0, FRAMES - 1, 1'b1, 1'b1);     // last managed frame
    push_req(ACT_CLAIM, 0, FRAMES, 1'b0, 1'b0);         // first frame past limit
    push_req(ACT_CLAIM, 'hFFFFF, 2, 1'b1, 1'b0);
    push_req(ACT_ALLOC, 0, 0, 1'b1, 1'b1);              // skips claimed frame 2
    push_req(ACT_FREE, 0, 'hFFFFF, 1'b1, 1'b1);         // free of frame zero
    push_req(ACT_FREE, 'hFFFFF, 0, 1'b0, 1'b1);         // free beyond storage
    push_req(ACT_FREE, FRAMES, 0, 1'b1, 1'b0);          // first frame past storage
    push_req(ACT_FREE, 1, 0, 1'b0, 1'b0);
    push_req(ACT_ALLOC, 0, 0, 1'b0, 1'b0);              // reuse frame 1
    push_req(ACT_NONE, 'hFFFFF, 'hFFFFF, 1'b1, 1'b1);   // unused code
    push_req(ACT_NONE, 0, 0, 1'b0, 1'b0);
    push_req(ACT_FREE, FRAMES - 1, 0, 1'b1, 1'b1);
    push_req(ACT_ALLOC, 1, 0, 1'b1, 1'b1);
    push_req(ACT_FREE, 0, 0, 1'b0, 1'b0);               // free of frame zero, ignored
    push_req(ACT_ALLOC, 0, 0, 1'b1, 1'b0);              // next lowest free, frame 4
    push_req(ACT_CLAIM, 0, 0, 1'b0, 1'b1);              // claim frame zero
    drain();

    // Sweep frame_count: tiny, zero, ragged, saturating, one past a word, word-aligned, reset, random.
    fc_plan = '{16'd64, 16'd0, 16'd100, 16'hFFFF, 16'd33, 16'd32, FC_RESET};
    fc_plan.push_back(FC_W'($urandom));
    for (p = 0; p < fc_plan.size(); p++) begin
      write_frame_count(fc_plan[p]);
      managed  = (int'(fc_plan[p]) > FRAMES) ? FRAMES : int'(fc_plan[p]);
      span     = (managed == 0) ? 64 : ((managed + 8 < 512) ? managed + 8 : 512);
      // Keep the saturating phase free of any idle cycles.
      idle_pct = (fc_plan[p] == 16'hFFFF) ? 0 : 26;
      for (i = 0; i < PHASE_REQS; i++)
        req_queue.push_back(random_request(span));
      drain();
    end

    // Let any stray strobe show up before judging.
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && entries_due.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/fba_pkg.sv
rtl/core/fba_ctrl.sv
rtl/core/fba_datapath.sv
rtl/core/frame_bitmap_allocator_top.sv
verif/frame_bitmap_allocator_top_test.sv
